/* hw/rtl/lft_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lft_pkg
// Shared types and codes for the logic formula tokenizer.
// ----------------------------------------------------------------------------
package lft_pkg;

   typedef logic [3:0] kind_type;

   localparam kind_type KIND_END     = 4'd0;
   localparam kind_type KIND_ERROR   = 4'd1;
   localparam kind_type KIND_FORALL  = 4'd2;
   localparam kind_type KIND_EXISTS  = 4'd3;
   localparam kind_type KIND_AND     = 4'd4;
   localparam kind_type KIND_OR      = 4'd5;
   localparam kind_type KIND_NOT     = 4'd6;
   localparam kind_type KIND_FALSUM  = 4'd7;
   localparam kind_type KIND_IMPLIES = 4'd8;
   localparam kind_type KIND_LPAREN  = 4'd9;
   localparam kind_type KIND_RPAREN  = 4'd10;
   localparam kind_type KIND_DOT     = 4'd11;
   localparam kind_type KIND_COMMA   = 4'd12;
   localparam kind_type KIND_UPPER   = 4'd13;
   localparam kind_type KIND_LOWER   = 4'd14;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_ARROW,
      MODE_UTF
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [7:0]  length;
      logic        last;
   } token_type;

   // up to three tokens caused by one byte, in emission order
   typedef struct packed {
      logic [1:0]          count;
      token_type [2:0]     tok;
   } burst_type;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

endpackage
`default_nettype wire

/* hw/rtl/lft_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lft_scan
// Scanner state and the per-byte step: decides the tokens one byte causes.
// ----------------------------------------------------------------------------
module lft_scan #(
   parameter int MAX_TOKEN_LEN = 255,
   parameter int TEXT_SIZE     = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         text_byte,
   input  wire logic               end_of_text,
   output lft_pkg::burst_type      burst
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
   localparam int POS_W = $clog2(TEXT_SIZE);

   lft_pkg::mode_type   mode_ff, mode_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [POS_W-1:0]    start_ff, start_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [5:0][7:0]     kw_ff, kw_in;
   logic                upper_ff, upper_in;
   logic [15:0]         held_ff, held_in;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
      if (p == POS_W'(TEXT_SIZE - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] l);
      if (int'(l) > 255) begin
         return 8'hFF;
      end
      return 8'(l);
   endfunction

   function automatic lft_pkg::token_type make_tok(input lft_pkg::kind_type k,
                                                   input logic [POS_W-1:0] s,
                                                   input logic [7:0] l);
      lft_pkg::token_type t;
      t.kind   = k;
      t.start  = 16'(s);
      t.length = l;
      t.last   = 1'b0;
      return t;
   endfunction

   // keyword match on the held prefix
   function automatic lft_pkg::kind_type ident_kind(input logic [5:0][7:0] kw,
                                                    input logic [LEN_W-1:0] l,
                                                    input logic up);
      if (l == LEN_W'(6) && kw[0] == "f" && kw[1] == "o" && kw[2] == "r" &&
          kw[3] == "a" && kw[4] == "l" && kw[5] == "l") begin
         return lft_pkg::KIND_FORALL;
      end
      if (l == LEN_W'(6) && kw[0] == "e" && kw[1] == "x" && kw[2] == "i" &&
          kw[3] == "s" && kw[4] == "t" && kw[5] == "s") begin
         return lft_pkg::KIND_EXISTS;
      end
      if (l == LEN_W'(3) && kw[0] == "a" && kw[1] == "n" && kw[2] == "d") begin
         return lft_pkg::KIND_AND;
      end
      if (l == LEN_W'(2) && kw[0] == "o" && kw[1] == "r") begin
         return lft_pkg::KIND_OR;
      end
      if (l == LEN_W'(3) && kw[0] == "n" && kw[1] == "o" && kw[2] == "t") begin
         return lft_pkg::KIND_NOT;
      end
      return up ? lft_pkg::KIND_UPPER : lft_pkg::KIND_LOWER;
   endfunction

   // byte classes
   logic              is_ws, is_alpha, is_upper, is_ident, is_arrow, is_lead;
   lft_pkg::kind_type single_kind;

   always_comb begin
      is_ws    = text_byte inside {[8'h09:8'h0D], 8'h20};
      is_upper = text_byte inside {["A":"Z"]};
      is_alpha = text_byte inside {["A":"Z"], ["a":"z"]};
      is_ident = is_alpha || (text_byte inside {["0":"9"], "_"});
      is_arrow = text_byte inside {"-", "="};
      is_lead  = text_byte inside {8'hC2, 8'hE2};
      case (text_byte)
         "(":     single_kind = lft_pkg::KIND_LPAREN;
         ")":     single_kind = lft_pkg::KIND_RPAREN;
         ".":     single_kind = lft_pkg::KIND_DOT;
         ",":     single_kind = lft_pkg::KIND_COMMA;
         default: single_kind = lft_pkg::KIND_ERROR;
      endcase
   end

   // multibyte sequence matching
   logic              utf_short, utf_hold;
   lft_pkg::kind_type utf_kind;
   logic              utf_hit;

   always_comb begin
      utf_short = len_ff < LEN_W'(2);
      utf_hold  = utf_short && held_ff[7:0] == 8'hE2 &&
                  (text_byte == 8'h88 || text_byte == 8'h8A);
      utf_hit   = 1'b0;
      utf_kind  = lft_pkg::KIND_ERROR;
      if (utf_short) begin
         if (held_ff[7:0] == 8'hC2 && text_byte == 8'hAC) begin
            utf_hit  = 1'b1;
            utf_kind = lft_pkg::KIND_NOT;
         end
      end else if (held_ff[15:8] == 8'h88) begin
         case (text_byte)
            8'h80: begin
               utf_hit  = 1'b1;
               utf_kind = lft_pkg::KIND_FORALL;
            end
            8'h83: begin
               utf_hit  = 1'b1;
               utf_kind = lft_pkg::KIND_EXISTS;
            end
            8'hA7: begin
               utf_hit  = 1'b1;
               utf_kind = lft_pkg::KIND_AND;
            end
            8'hA8: begin
               utf_hit  = 1'b1;
               utf_kind = lft_pkg::KIND_OR;
            end
            default: begin
               utf_hit  = 1'b0;
               utf_kind = lft_pkg::KIND_ERROR;
            end
         endcase
      end else if (held_ff[15:8] == 8'h8A && text_byte == 8'hA5) begin
         utf_hit  = 1'b1;
         utf_kind = lft_pkg::KIND_FALSUM;
      end
   end

   // tokens: p0 flushes the pending one, p1 is a held second byte, f is fresh
   lft_pkg::token_type p0, p1, f;
   logic               p0_v, p1_v, f_v, run_idle;

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;
      kw_in    = kw_ff;
      upper_in = upper_ff;
      held_in  = held_ff;
      p0       = '0;
      p1       = '0;
      f        = '0;
      p0_v     = 1'b0;
      p1_v     = 1'b0;
      f_v      = 1'b0;
      run_idle = 1'b0;

      if (end_of_text) begin
         case (mode_ff)
            lft_pkg::MODE_IDENT: begin
               p0_v = 1'b1;
               p0   = make_tok(ident_kind(kw_ff, len_ff, upper_ff), start_ff,
                               sat_len(len_ff));
            end
            lft_pkg::MODE_ARROW: begin
               p0_v = 1'b1;
               p0   = make_tok(lft_pkg::KIND_ERROR, start_ff, 8'd1);
            end
            lft_pkg::MODE_UTF: begin
               p0_v = 1'b1;
               p0   = make_tok(lft_pkg::KIND_ERROR, start_ff, 8'd1);
               p1_v = !utf_short;
               p1   = make_tok(lft_pkg::KIND_ERROR, next_pos(start_ff), 8'd1);
            end
            default: begin
               p0_v = 1'b0;
            end
         endcase
         f_v      = 1'b1;
         f        = make_tok(lft_pkg::KIND_END, pos_ff, 8'd0);
         mode_in  = lft_pkg::MODE_IDLE;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         kw_in    = '0;
         upper_in = 1'b0;
         held_in  = '0;
      end else begin
         pos_in = next_pos(pos_ff);
         case (mode_ff)
            lft_pkg::MODE_IDENT: begin
               if (is_ident) begin
                  for (int i = 0; i < 6; i++) begin
                     if (len_ff == LEN_W'(i)) begin
                        kw_in[i] = text_byte;
                     end
                  end
                  if (len_ff < LEN_W'(MAX_TOKEN_LEN)) begin
                     len_in = len_ff + 1'b1;
                  end
               end else begin
                  p0_v     = 1'b1;
                  p0       = make_tok(ident_kind(kw_ff, len_ff, upper_ff), start_ff,
                                      sat_len(len_ff));
                  mode_in  = lft_pkg::MODE_IDLE;
                  run_idle = 1'b1;
               end
            end
            lft_pkg::MODE_ARROW: begin
               mode_in = lft_pkg::MODE_IDLE;
               p0_v    = 1'b1;
               if (text_byte == ">") begin
                  p0 = make_tok(lft_pkg::KIND_IMPLIES, start_ff, 8'd2);
               end else begin
                  p0       = make_tok(lft_pkg::KIND_ERROR, start_ff, 8'd1);
                  run_idle = 1'b1;
               end
            end
            lft_pkg::MODE_UTF: begin
               if (utf_hit) begin
                  p0_v    = 1'b1;
                  p0      = make_tok(utf_kind, start_ff, sat_len(len_ff) + 8'd1);
                  mode_in = lft_pkg::MODE_IDLE;
                  held_in = '0;
               end else if (utf_hold) begin
                  held_in = {text_byte, held_ff[7:0]};
                  len_in  = LEN_W'(2);
               end else begin
                  p0_v     = 1'b1;
                  p0       = make_tok(lft_pkg::KIND_ERROR, start_ff, 8'd1);
                  p1_v     = !utf_short;
                  p1       = make_tok(lft_pkg::KIND_ERROR, next_pos(start_ff), 8'd1);
                  mode_in  = lft_pkg::MODE_IDLE;
                  held_in  = '0;
                  run_idle = 1'b1;
               end
            end
            default: begin
               run_idle = 1'b1;
            end
         endcase

         // a byte seen with nothing pending
         if (run_idle) begin
            if (is_alpha || text_byte == "_") begin
               mode_in  = lft_pkg::MODE_IDENT;
               start_in = pos_ff;
               len_in   = LEN_W'(1);
               kw_in    = '0;
               kw_in[0] = text_byte;
               upper_in = is_upper;
            end else if (is_arrow) begin
               mode_in  = lft_pkg::MODE_ARROW;
               start_in = pos_ff;
            end else if (is_lead) begin
               mode_in  = lft_pkg::MODE_UTF;
               start_in = pos_ff;
               len_in   = LEN_W'(1);
               held_in  = {8'h00, text_byte};
            end else if (!is_ws) begin
               f_v = 1'b1;
               f   = make_tok(single_kind, pos_ff, 8'd1);
            end
         end
      end
   end

   // pack in order p0, p1, f; p1 never stands without p0
   always_comb begin
      burst.count  = {1'b0, p0_v} + {1'b0, p1_v} + {1'b0, f_v};
      burst.tok[0] = p0_v ? p0 : f;
      burst.tok[1] = p1_v ? p1 : f;
      burst.tok[2] = f;
      for (int i = 0; i < 3; i++) begin
         burst.tok[i].last = (burst.count == 2'(i + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lft_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         kw_ff    <= '0;
         upper_ff <= 1'b0;
         held_ff  <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kw_ff    <= kw_in;
         upper_ff <= upper_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/lft_outq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lft_outq
// Token queue: takes a burst of up to three tokens, hands out one per transfer.
// ----------------------------------------------------------------------------
module lft_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lft_pkg::burst_type burst,
   input  wire logic               pop,
   output logic                    head_valid,
   output lft_pkg::token_type      head,
   output logic                    room
);

   lft_pkg::token_type                 q_ff [lft_pkg::OQ_DEPTH];
   logic [lft_pkg::OQ_PTR_W-1:0]       wr_ff, wr_in;
   logic [lft_pkg::OQ_PTR_W-1:0]       rd_ff, rd_in;
   logic [lft_pkg::OQ_CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]                         n_push;
   logic                               do_pop;

   always_comb begin
      head_valid = cnt_ff != '0;
      head       = q_ff[rd_ff];
      n_push     = push ? burst.count : 2'd0;
      do_pop     = pop && head_valid;
      // a whole burst always fits
      room       = cnt_ff <= lft_pkg::OQ_CNT_W'(lft_pkg::OQ_DEPTH - 3);
      wr_in      = wr_ff + lft_pkg::OQ_PTR_W'(n_push);
      rd_in      = rd_ff + lft_pkg::OQ_PTR_W'(do_pop);
      cnt_in     = cnt_ff + lft_pkg::OQ_CNT_W'(n_push) - lft_pkg::OQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < n_push) begin
            q_ff[wr_ff + lft_pkg::OQ_PTR_W'(i)] <= burst.tok[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/logic_formula_tokenizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// logic_formula_tokenizer
// Byte-stream tokenizer for first-order logic formulas.
//
//   channel   dir   tdata bits (low first)                 tuser            tlast
//   req_      in    text_byte[7:0]                         -                end_of_text
//   rsp_      out   start_offset[15:0] token_length[23:16] token_kind[3:0]  last_of_run
//
// One byte is taken per cycle while the token queue has room. The byte is first
// registered at the input; its tokens are then written into the token queue,
// whose head drives rsp_. The next byte waits while more than one token sits
// in the 4-entry token queue.
// Synchronous reset returns the scanner to idle at offset zero.
// A stalled rsp side backs up through the queue to req_tready.
// ----------------------------------------------------------------------------
module logic_formula_tokenizer #(
   parameter int MAX_TOKEN_LEN = 255,
   parameter int TEXT_SIZE     = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // text_byte
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // start_offset, token_length
   output logic [3:0]       rsp_tuser,   // token_kind
   output logic             rsp_tlast    // last_of_run
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_end_ff;
   logic               go, room;
   lft_pkg::burst_type burst;
   lft_pkg::token_type head;

   always_comb begin
      go          = in_valid_ff && room;
      req_tready  = !in_valid_ff || go;
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   lft_scan #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .TEXT_SIZE     (TEXT_SIZE)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (go),
      .text_byte   (in_byte_ff),
      .end_of_text (in_end_ff),
      .burst       (burst)
   );

   lft_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (go),
      .burst      (burst),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head       (head),
      .room       (room)
   );

   always_comb begin
      rsp_tdata = {head.length, head.start};
      rsp_tuser = head.kind;
      rsp_tlast = head.last;
   end

endmodule
`default_nettype wire

/* hw/rtl/lft_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lft_checker
// Port-level checks on the token stream of the tokenizer.
// ----------------------------------------------------------------------------
module lft_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic [3:0] kind;
   logic [7:0] length;

   assign kind   = rsp_tuser;
   assign length = rsp_tdata[23:16];

   // stalled transfer keeps its token
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp token changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("token shown right after reset");

   // end token closes the run and has no length
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == lft_pkg::KIND_END |-> length == 8'd0 && rsp_tlast)
      else $error("malformed end token");

   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (kind == lft_pkg::KIND_ERROR || kind == lft_pkg::KIND_LPAREN ||
                     kind == lft_pkg::KIND_RPAREN || kind == lft_pkg::KIND_DOT ||
                     kind == lft_pkg::KIND_COMMA) |-> length == 8'd1)
      else $error("single-byte token with wrong length");

   a_implies_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == lft_pkg::KIND_IMPLIES |-> length == 8'd2)
      else $error("implies token with wrong length");

endmodule

bind logic_formula_tokenizer lft_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logic_formula_tokenizer testbench
// Feeds formula text byte by byte: a short table of hand-picked bytes, then
// random well-formed and broken token sequences. Every token is checked
// against an in-bench scanner, or against the table for pinned table rows.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT = 1000;
   localparam int LEN_CAP     = 255;
   localparam int ITEM_TARGET = 245;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] UTF_C2     = 8'hC2;
   localparam logic [7:0] UTF_E2     = 8'hE2;
   localparam logic [7:0] UTF_MID_88 = 8'h88;
   localparam logic [7:0] UTF_MID_8A = 8'h8A;
   localparam logic [7:0] UTF_NOT    = 8'hAC;
   localparam logic [7:0] UTF_FORALL = 8'h80;
   localparam logic [7:0] UTF_EXISTS = 8'h83;
   localparam logic [7:0] UTF_AND    = 8'hA7;
   localparam logic [7:0] UTF_OR     = 8'hA8;
   localparam logic [7:0] UTF_FALSUM = 8'hA5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // text_byte
   logic        req_tlast = 1'b0;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // start_offset, token_length
   logic [3:0]  rsp_tuser;           // token_kind
   logic        rsp_tlast;           // last_of_run

   logic_formula_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scanner state
   lft_pkg::mode_type scan_state;
   logic [15:0] scan_pos;
   logic [15:0] tok_start;
   int unsigned tok_len;
   logic [47:0] id_text;     // first six identifier bytes, latest in the low byte
   logic        id_upper;
   logic [7:0]  utf_lead;
   logic [7:0]  utf_second;

   lft_pkg::token_type step_tokens[$];
   lft_pkg::token_type expected_tokens[$];
   logic [8:0]  text_bytes[$];   // {end_of_text, text_byte}
   int          mismatch_count = 0;
   int          items_sent = 0;

   typedef struct packed {
      logic [7:0]        text;
      logic              eot;
      logic              pinned;
      lft_pkg::kind_type kind;
      logic [15:0]       start;
      logic [7:0]        len;
   } stim_row_type;

   stim_row_type directed_rows [25] = '{
      '{8'h00, 1'b0, 1'b1, lft_pkg::KIND_ERROR,   16'd0, 8'd1},   // zero byte
      '{"9",   1'b0, 1'b1, lft_pkg::KIND_ERROR,   16'd1, 8'd1},   // digit cannot start a name
      '{"(",   1'b0, 1'b1, lft_pkg::KIND_LPAREN,  16'd2, 8'd1},
      '{")",   1'b0, 1'b1, lft_pkg::KIND_RPAREN,  16'd3, 8'd1},
      '{".",   1'b0, 1'b1, lft_pkg::KIND_DOT,     16'd4, 8'd1},
      '{",",   1'b0, 1'b1, lft_pkg::KIND_COMMA,   16'd5, 8'd1},
      '{8'hFF, 1'b0, 1'b1, lft_pkg::KIND_ERROR,   16'd6, 8'd1},
      '{"-",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{">",   1'b0, 1'b1, lft_pkg::KIND_IMPLIES, 16'd7, 8'd2},
      '{"=",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{"x",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},   // lone equals
      '{" ",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'hE2, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'h88, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{"A",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},   // broken three-byte symbol
      '{8'hC2, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'hAC, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{"_",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{"=",   1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'hE2, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'h8A, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'h00, 1'b1, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},   // flush two held bytes, then end
      '{8'h00, 1'b1, 1'b1, lft_pkg::KIND_END,     16'd0, 8'd0},   // offset restarts after end
      '{8'hC2, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0},
      '{8'h80, 1'b0, 1'b0, lft_pkg::KIND_END,     16'd0, 8'd0}
   };

   string kw_names [5] = '{"forall", "exists", "and", "or", "not"};

   function automatic bit is_space(logic [7:0] b);
      return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic bit is_ident_char(logic [7:0] b);
      return is_alpha(b) || (b >= "0" && b <= "9") || b == "_";
   endfunction

   task automatic clear_scanner();
      scan_state = lft_pkg::MODE_IDLE;
      scan_pos   = '0;
      tok_start  = '0;
      tok_len    = 0;
      id_text    = '0;
      id_upper   = 1'b0;
      utf_lead   = '0;
      utf_second = '0;
   endtask

   task automatic add_token(lft_pkg::kind_type k, logic [15:0] s, int unsigned n);
      lft_pkg::token_type t;
      if (step_tokens.size() < 3) begin
         t.kind   = k;
         t.start  = s;
         t.length = (n > LEN_CAP) ? 8'(LEN_CAP) : 8'(n);
         t.last   = 1'b0;
         step_tokens.push_back(t);
      end
   endtask

   task automatic close_ident();
      lft_pkg::kind_type k;
      k = id_upper ? lft_pkg::KIND_UPPER : lft_pkg::KIND_LOWER;
      if (tok_len == 6 && id_text == "forall")      k = lft_pkg::KIND_FORALL;
      else if (tok_len == 6 && id_text == "exists") k = lft_pkg::KIND_EXISTS;
      else if (tok_len == 3 && id_text == "and")    k = lft_pkg::KIND_AND;
      else if (tok_len == 2 && id_text == "or")     k = lft_pkg::KIND_OR;
      else if (tok_len == 3 && id_text == "not")    k = lft_pkg::KIND_NOT;
      add_token(k, tok_start, tok_len);
      scan_state = lft_pkg::MODE_IDLE;
   endtask

   task automatic drop_utf();
      add_token(lft_pkg::KIND_ERROR, tok_start, 1);
      if (tok_len >= 2) add_token(lft_pkg::KIND_ERROR, tok_start + 16'd1, 1);
      scan_state = lft_pkg::MODE_IDLE;
      utf_lead   = '0;
      utf_second = '0;
   endtask

   task automatic start_byte(logic [7:0] b);
      if (is_space(b)) begin
      end else if (is_alpha(b) || b == "_") begin
         scan_state = lft_pkg::MODE_IDENT;
         tok_start  = scan_pos;
         tok_len    = 1;
         id_text    = {40'd0, b};
         id_upper   = (b >= "A" && b <= "Z");
      end else if (b == "-" || b == "=") begin
         scan_state = lft_pkg::MODE_ARROW;
         tok_start  = scan_pos;
      end else if (b == UTF_C2 || b == UTF_E2) begin
         scan_state = lft_pkg::MODE_UTF;
         tok_start  = scan_pos;
         tok_len    = 1;
         utf_lead   = b;
      end else begin
         case (b)
            "(":     add_token(lft_pkg::KIND_LPAREN, scan_pos, 1);
            ")":     add_token(lft_pkg::KIND_RPAREN, scan_pos, 1);
            ".":     add_token(lft_pkg::KIND_DOT, scan_pos, 1);
            ",":     add_token(lft_pkg::KIND_COMMA, scan_pos, 1);
            default: add_token(lft_pkg::KIND_ERROR, scan_pos, 1);
         endcase
      end
   endtask

   task automatic utf_byte(logic [7:0] b);
      lft_pkg::kind_type k;
      k = lft_pkg::KIND_END;   // stands for no match
      if (tok_len < 2) begin
         if (utf_lead == UTF_C2 && b == UTF_NOT) k = lft_pkg::KIND_NOT;
         else if (utf_lead == UTF_E2 && (b == UTF_MID_88 || b == UTF_MID_8A)) begin
            utf_second = b;
            tok_len    = 2;
            return;
         end
      end else if (utf_second == UTF_MID_88) begin
         case (b)
            UTF_FORALL: k = lft_pkg::KIND_FORALL;
            UTF_EXISTS: k = lft_pkg::KIND_EXISTS;
            UTF_AND:    k = lft_pkg::KIND_AND;
            UTF_OR:     k = lft_pkg::KIND_OR;
            default:    k = lft_pkg::KIND_END;
         endcase
      end else if (utf_second == UTF_MID_8A && b == UTF_FALSUM) begin
         k = lft_pkg::KIND_FALSUM;
      end
      if (k != lft_pkg::KIND_END) begin
         add_token(k, tok_start, tok_len + 1);
         scan_state = lft_pkg::MODE_IDLE;
         utf_lead   = '0;
         utf_second = '0;
      end else begin
         drop_utf();
         start_byte(b);
      end
   endtask

   // tokens caused by one accepted byte land in step_tokens
   task automatic tokenize_byte(logic [7:0] b, logic e);
      lft_pkg::token_type t;
      step_tokens.delete();
      if (e) begin
         case (scan_state)
            lft_pkg::MODE_IDENT: close_ident();
            lft_pkg::MODE_ARROW: add_token(lft_pkg::KIND_ERROR, tok_start, 1);
            lft_pkg::MODE_UTF:   drop_utf();
            default:             ;
         endcase
         add_token(lft_pkg::KIND_END, scan_pos, 0);
         clear_scanner();
      end else begin
         case (scan_state)
            lft_pkg::MODE_IDENT: begin
               if (is_ident_char(b)) begin
                  if (tok_len < 6) id_text = {id_text[39:0], b};
                  if (tok_len < LEN_CAP) tok_len++;
               end else begin
                  close_ident();
                  start_byte(b);
               end
            end
            lft_pkg::MODE_ARROW: begin
               scan_state = lft_pkg::MODE_IDLE;
               if (b == ">") begin
                  add_token(lft_pkg::KIND_IMPLIES, tok_start, 2);
               end else begin
                  add_token(lft_pkg::KIND_ERROR, tok_start, 1);
                  start_byte(b);
               end
            end
            lft_pkg::MODE_UTF: utf_byte(b);
            default:           start_byte(b);
         endcase
         scan_pos = scan_pos + 16'd1;
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens.pop_back();
         t.last = 1'b1;
         step_tokens.push_back(t);
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic put_byte(logic [7:0] b, logic e, bit gaps, bit pinned,
                           lft_pkg::token_type pin);
      int gap;
      gap = gaps ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tokenize_byte(b, e);
      if (pinned) expected_tokens.push_back(pin);
      else while (step_tokens.size() > 0) expected_tokens.push_back(step_tokens.pop_front());
      items_sent++;
      @(negedge clock);
   endtask

   task automatic push_text(logic [7:0] b);
      text_bytes.push_back({1'b0, b});
   endtask

   task automatic add_seq3(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      push_text(b0);
      push_text(b1);
      push_text(b2);
   endtask

   task automatic add_str(string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back({1'b0, 8'(s[i])});
   endtask

   function automatic logic [7:0] rand_ident_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return "_";
   endfunction

   function automatic logic [7:0] rand_space();
      return ($urandom_range(0, 7) < 3) ? CH_SPACE : 8'(8'h09 + $urandom_range(0, 4));
   endfunction

   task automatic add_random_ident(int n);
      int r;
      r = $urandom_range(0, 52);
      if (r < 26)      text_bytes.push_back({1'b0, 8'("a" + r)});
      else if (r < 52) text_bytes.push_back({1'b0, 8'("A" + r - 26)});
      else             text_bytes.push_back({1'b0, 8'("_")});
      for (int i = 1; i < n; i++) text_bytes.push_back({1'b0, rand_ident_char()});
   endtask

   task automatic add_random_token();
      int r;
      string s;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         add_str(kw_names[$urandom_range(0, 4)]);
      end else if (r < 20) begin
         // near miss of a keyword
         s = kw_names[$urandom_range(0, 4)];
         if ($urandom_range(0, 1)) begin
            add_str(s);
            text_bytes.push_back({1'b0, rand_ident_char()});
         end else begin
            add_str(s.substr(0, s.len() - 2));
         end
      end else if (r < 40) begin
         add_random_ident($urandom_range(1, 8));
      end else if (r < 48) begin
         add_str($urandom_range(0, 1) ? "->" : "=>");
      end else if (r < 53) begin
         add_str($urandom_range(0, 1) ? "-" : "=");
      end else if (r < 65) begin
         case ($urandom_range(0, 3))
            0: add_str("(");
            1: add_str(")");
            2: add_str(".");
            default: add_str(",");
         endcase
      end else if (r < 77) begin
         case ($urandom_range(0, 5))
            0: add_seq3(UTF_E2, UTF_MID_88, UTF_FORALL);
            1: add_seq3(UTF_E2, UTF_MID_88, UTF_EXISTS);
            2: add_seq3(UTF_E2, UTF_MID_88, UTF_AND);
            3: add_seq3(UTF_E2, UTF_MID_88, UTF_OR);
            4: add_seq3(UTF_E2, UTF_MID_8A, UTF_FALSUM);
            default: begin
               push_text(UTF_C2);
               push_text(UTF_NOT);
            end
         endcase
      end else if (r < 85) begin
         // broken multibyte symbol
         case ($urandom_range(0, 2))
            0: push_text(UTF_C2);
            1: push_text(UTF_E2);
            default: begin
               push_text(UTF_E2);
               push_text($urandom_range(0, 1) ? UTF_MID_88 : UTF_MID_8A);
            end
         endcase
         text_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
      end else if (r < 90) begin
         text_bytes.push_back({1'b0, 8'("0" + $urandom_range(0, 9))});
      end else begin
         text_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
      if ($urandom_range(0, 9) < 6) begin
         text_bytes.push_back({1'b0, rand_space()});
         if ($urandom_range(0, 3) == 0) text_bytes.push_back({1'b0, rand_space()});
      end
   endtask

   task automatic build_text(int tokens);
      for (int i = 0; i < tokens; i++) add_random_token();
      if ($urandom_range(0, 99) < 85) text_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
   endtask

   task automatic send_text(bit gaps);
      lft_pkg::token_type none;
      logic [8:0] item;
      none = '0;
      while (text_bytes.size() > 0) begin
         item = text_bytes.pop_front();
         put_byte(item[7:0], item[8], gaps, 1'b0, none);
      end
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // receiver: runs of ready, broken by stalls of random length
   int ready_run = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (ready_run > 0) begin
            ready_run--;
         end else begin
            ready_run  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
            stall_left = idle_len();
         end
      end
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin : token_check
      lft_pkg::token_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("token with nothing pending: kind %0d start %0d len %0d",
                                         rsp_tuser, rsp_tdata[15:0], rsp_tdata[23:16]));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("kind %0d, wanted %0d", rsp_tuser, want.kind));
               if (rsp_tdata[15:0] !== want.start)
                  report_mismatch($sformatf("start %0d, wanted %0d", rsp_tdata[15:0], want.start));
               if (rsp_tdata[23:16] !== want.length)
                  report_mismatch($sformatf("length %0d, wanted %0d", rsp_tdata[23:16],
                                            want.length));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %0b, wanted %0b", rsp_tlast, want.last));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** logic_formula_tokenizer: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      lft_pkg::token_type pin;
      clear_scanner();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         pin.kind   = directed_rows[i].kind;
         pin.start  = directed_rows[i].start;
         pin.length = directed_rows[i].len;
         pin.last   = 1'b1;
         put_byte(directed_rows[i].text, directed_rows[i].eot, 1'b1,
                  directed_rows[i].pinned, pin);
      end

      while (items_sent < ITEM_TARGET) begin
         build_text($urandom_range(1, 12));
         send_text($urandom_range(0, 4) != 0);
      end
      req_tvalid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** logic_formula_tokenizer: PASSED **");
      end else begin
         $display("** logic_formula_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule
